FILE: hw/rtl/obtl_pkg.sv
package obtl_pkg;

	localparam int MAX_LEVELS = 32;
	localparam int PRICE_W = 40;
	localparam int QTY_W = 40;
	localparam int ID_W = 64;
	localparam int CNT_W = 6;
	localparam int DEPTH_W = 45;
	localparam int MID_W = 41;
	localparam int SPREAD_W = 32;
	localparam int FRAC_BITS = 16;
	localparam logic [14:0] BPS_SCALE = 15'd20000;

	localparam logic OP_SNAPSHOT = 1'b0;
	localparam logic OP_UPDATE = 1'b1;
	localparam logic SIDE_BID = 1'b0;
	localparam logic SIDE_ASK = 1'b1;

	typedef struct packed {
		logic opcode;
		logic side;
		logic has_level;
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0] qty;
		logic [ID_W-1:0] prev_update_id;
		logic [ID_W-1:0] end_update_id;
		logic last_of_message;
	} in_item_t;

	typedef struct packed {
		logic accepted;
		logic resync_needed;
		logic [PRICE_W-1:0] top_bid;
		logic [PRICE_W-1:0] top_ask;
		logic [MID_W-1:0] mid_times_two;
		logic signed [SPREAD_W-1:0] spread_bps_q16;
		logic [DEPTH_W-1:0] bid_depth;
		logic [DEPTH_W-1:0] ask_depth;
		logic [CNT_W-1:0] bid_levels;
		logic [CNT_W-1:0] ask_levels;
	} out_item_t;

	// control from sequencer to a side chain
	typedef struct packed {
		logic clear;
		logic insert;
		logic sum_start;
		logic sum_step;
	} chain_ctl_t;

endpackage

FILE: hw/rtl/order_book_top_levels.sv
// order book top levels
// in channel: in_valid/in_ready carry one level or closing item per transfer (in_item)
// out channel: out_valid/out_ready carry one top-of-book result at each message end
// cfg_we/cfg_wdata write depth_levels (reset value 5); the user must do so only while
// idle, which the block does not enforce; each level is placed by one insertion step of
// the cell chain, an item passing through ST_IDLE and ST_INS; after the closing transfer
// ST_INS inserts its level and ST_PREP starts the depth summation and the spread divider;
// the divider makes one quotient bit per cycle, the summation walks MAX_LEVELS cells
// meanwhile, and out_valid rises once both are done; the next item is taken after that
// the result then sits in the output register until taken
// a new item is taken while a result waits, unless that item ends a message
// reset empties both sides, clears the sequence state and the resync flag
// a stalled receiver holds the result register and eventually the input
module order_book_top_levels (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  obtl_pkg::in_item_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output obtl_pkg::out_item_t out_item,
	input  logic cfg_we,
	input  logic [obtl_pkg::CNT_W-1:0] cfg_wdata
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_INS  = 5'b00010,
		ST_PREP = 5'b00100,
		ST_SUM  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q;
	obtl_pkg::in_item_t item_q;
	logic [obtl_pkg::CNT_W-1:0] depth_q;
	logic [obtl_pkg::ID_W-1:0] last_id_q;
	logic init_q, resync_q, inside_q, taken_q, out_valid_q;
	logic [8:0] cnt_q;
	obtl_pkg::out_item_t out_q;
	obtl_pkg::chain_ctl_t bid_ctl, ask_ctl;
	logic [obtl_pkg::CNT_W-1:0] bid_held, ask_held;
	logic [obtl_pkg::PRICE_W-1:0] bid_best, ask_best, bb, ba;
	logic [obtl_pkg::DEPTH_W-1:0] bid_depth, ask_depth;
	logic div_start, div_busy, both, in_fire, first_take, reject;
	logic [obtl_pkg::SPREAD_W-1:0] spread;

	assign in_fire = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE) && !(in_item.last_of_message && out_valid_q);
	assign reject = (in_item.opcode == obtl_pkg::OP_UPDATE) && init_q &&
		(in_item.prev_update_id != last_id_q);
	assign first_take = in_fire && !inside_q && !reject;
	assign bb = (bid_held != '0) ? bid_best : '0;
	assign ba = (ask_held != '0) ? ask_best : '0;
	assign both = (bid_held != '0) && (ask_held != '0);
	// the cycle after the closing level went in
	assign div_start = (state_q == ST_PREP);

	always_comb begin
		bid_ctl = '0;
		ask_ctl = '0;
		bid_ctl.clear = first_take;
		ask_ctl.clear = first_take;
		if (state_q == ST_INS && taken_q && item_q.has_level) begin
			bid_ctl.insert = item_q.side == obtl_pkg::SIDE_BID;
			ask_ctl.insert = item_q.side == obtl_pkg::SIDE_ASK;
		end
		bid_ctl.sum_start = div_start;
		ask_ctl.sum_start = div_start;
		bid_ctl.sum_step = state_q == ST_SUM;
		ask_ctl.sum_step = state_q == ST_SUM;
	end

	obtl_side #(.N(obtl_pkg::MAX_LEVELS), .PW(obtl_pkg::PRICE_W), .QW(obtl_pkg::QTY_W),
		.CW(obtl_pkg::CNT_W)) u_bid (
		.clk(clk), .arst_n(arst_n), .descending(1'b1), .ctl(bid_ctl),
		.new_price(item_q.price), .new_qty(item_q.qty), .depth_levels(depth_q),
		.held(bid_held), .best(bid_best), .depth(bid_depth)
	);
	obtl_side #(.N(obtl_pkg::MAX_LEVELS), .PW(obtl_pkg::PRICE_W), .QW(obtl_pkg::QTY_W),
		.CW(obtl_pkg::CNT_W)) u_ask (
		.clk(clk), .arst_n(arst_n), .descending(1'b0), .ctl(ask_ctl),
		.new_price(item_q.price), .new_qty(item_q.qty), .depth_levels(depth_q),
		.held(ask_held), .best(ask_best), .depth(ask_depth)
	);

	obtl_spread u_spread (
		.clk(clk), .arst_n(arst_n), .start(div_start), .bid(bb), .ask(ba),
		.busy(div_busy), .result(spread)
	);

	always_ff @(posedge clk) begin
		if (in_fire) item_q <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			depth_q <= obtl_pkg::CNT_W'(5);
			last_id_q <= '0;
			init_q <= 1'b0;
			resync_q <= 1'b0;
			inside_q <= 1'b0;
			taken_q <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) depth_q <= cfg_wdata;
			if (state_q == ST_DONE && !div_busy) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_INS;
						if (!inside_q) begin
							inside_q <= 1'b1;
							taken_q <= !reject;
							if (reject) begin
								resync_q <= 1'b1;
							end else begin
								last_id_q <= in_item.end_update_id;
								init_q <= 1'b1;
								if (in_item.opcode == obtl_pkg::OP_SNAPSHOT) resync_q <= 1'b0;
							end
						end
					end
				end
				ST_INS: begin
					if (item_q.last_of_message) state_q <= ST_PREP;
					else state_q <= ST_IDLE;
				end
				ST_PREP: begin
					state_q <= ST_SUM;
					cnt_q <= 9'(obtl_pkg::MAX_LEVELS);
				end
				ST_SUM: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == 9'd1) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!div_busy) begin
						inside_q <= 1'b0;
						taken_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && !div_busy) begin
			out_q.accepted <= taken_q;
			out_q.resync_needed <= resync_q;
			out_q.top_bid <= bb;
			out_q.top_ask <= ba;
			out_q.mid_times_two <= both ? (obtl_pkg::MID_W'(bb) + obtl_pkg::MID_W'(ba)) : '0;
			out_q.spread_bps_q16 <= (both && (bb != '0 || ba != '0)) ? spread : '0;
			out_q.bid_depth <= bid_depth;
			out_q.ask_depth <= ask_depth;
			out_q.bid_levels <= bid_held;
			out_q.ask_levels <= ask_held;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> state_q == ST_IDLE) else $error("item taken while busy");
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bid_held <= obtl_pkg::CNT_W'(obtl_pkg::MAX_LEVELS) &&
		ask_held <= obtl_pkg::CNT_W'(obtl_pkg::MAX_LEVELS))
		else $error("level count overflow");
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
`endif
endmodule

FILE: hw/rtl/obtl_cell.sv
module obtl_cell #(
	parameter int PW = 40,
	parameter int QW = 40
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          descending,
	input  obtl_pkg::chain_ctl_t ctl,
	input  logic [PW-1:0] new_price,
	input  logic [QW-1:0] new_qty,
	// neighbor toward the top of book
	input  logic          up_valid,
	input  logic          up_after,
	input  logic [PW-1:0] up_price,
	input  logic [QW-1:0] up_qty,
	output logic          valid,
	output logic          after,
	output logic [PW-1:0] price,
	output logic [QW-1:0] qty
);
	logic          valid_q;
	logic [PW-1:0] price_q;
	logic [QW-1:0] qty_q;

	// new level goes before this cell
	assign after = valid_q && (descending ? (price_q < new_price) : (price_q > new_price));
	assign valid = valid_q;
	assign price = price_q;
	assign qty = qty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.insert) begin
			valid_q <= valid_q || up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (after) begin
				if (up_after) begin
					price_q <= up_price;
					qty_q <= up_qty;
				end else begin
					price_q <= new_price;
					qty_q <= new_qty;
				end
			end else if (!valid_q && (up_valid && !up_after)) begin
				price_q <= new_price;
				qty_q <= new_qty;
			end else if (!valid_q && up_after) begin
				price_q <= up_price;
				qty_q <= up_qty;
			end
		end
	end
endmodule

FILE: hw/rtl/obtl_side.sv
module obtl_side #(
	parameter int N = 32,
	parameter int PW = 40,
	parameter int QW = 40,
	parameter int CW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          descending,
	input  obtl_pkg::chain_ctl_t ctl,
	input  logic [PW-1:0] new_price,
	input  logic [QW-1:0] new_qty,
	input  logic [CW-1:0] depth_levels,
	output logic [CW-1:0] held,
	output logic [PW-1:0] best,
	output logic [obtl_pkg::DEPTH_W-1:0] depth
);
	logic [N-1:0]  v, af;
	logic [PW-1:0] pr [N];
	logic [QW-1:0] qt [N];
	logic [CW-1:0] held_q, left_q;
	logic [obtl_pkg::DEPTH_W-1:0] acc_q;
	logic [QW-1:0] rot_q [N];
	logic          full;

	assign full = (held_q == CW'(N));
	assign held = held_q;
	assign best = pr[0];
	assign depth = acc_q;

	// the stored order is kept; a shadow rotation walks quantities past the summer
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic up_v, up_a;
		logic [PW-1:0] up_p;
		logic [QW-1:0] up_q;
		obtl_pkg::chain_ctl_t c;
		if (i == 0) begin : g_first
			assign up_v = 1'b1;
			assign up_a = 1'b0;
			assign up_p = new_price;
			assign up_q = new_qty;
		end else begin : g_rest
			assign up_v = v[i-1];
			assign up_a = af[i-1];
			assign up_p = pr[i-1];
			assign up_q = qt[i-1];
		end
		always_comb begin
			c = ctl;
			c.insert = ctl.insert && !full;
		end
		obtl_cell #(.PW(PW), .QW(QW)) u_cell (
			.clk(clk), .arst_n(arst_n), .descending(descending), .ctl(c),
			.new_price(new_price), .new_qty(new_qty),
			.up_valid(up_v), .up_after(up_a), .up_price(up_p), .up_qty(up_q),
			.valid(v[i]), .after(af[i]), .price(pr[i]), .qty(qt[i])
		);
		if (i == N-1) begin : g_tail
			always_ff @(posedge clk) begin
				if (ctl.sum_start) rot_q[i] <= qt[i];
				else if (ctl.sum_step) rot_q[i] <= '0;
			end
		end else begin : g_mid
			always_ff @(posedge clk) begin
				if (ctl.sum_start) rot_q[i] <= qt[i];
				else if (ctl.sum_step) rot_q[i] <= rot_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			left_q <= '0;
			acc_q <= '0;
		end else begin
			if (ctl.clear) held_q <= '0;
			else if (ctl.insert && !full) held_q <= held_q + 1'b1;
			if (ctl.sum_start) begin
				acc_q <= '0;
				left_q <= (depth_levels < held_q) ? depth_levels : held_q;
			end else if (ctl.sum_step && left_q != '0) begin
				acc_q <= acc_q + obtl_pkg::DEPTH_W'(rot_q[0]);
				left_q <= left_q - 1'b1;
			end
		end
	end
endmodule

FILE: hw/rtl/obtl_spread.sv
module obtl_spread (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [obtl_pkg::PRICE_W-1:0] bid,
	input  logic [obtl_pkg::PRICE_W-1:0] ask,
	output logic busy,
	output logic [obtl_pkg::SPREAD_W-1:0] result
);
	localparam int SW = obtl_pkg::PRICE_W + 1;
	localparam int NW = SW + 15 + obtl_pkg::FRAC_BITS;
	localparam int STEPS = NW;
	logic [NW-1:0] num_q, quo_q;
	logic [SW:0]   rem_q;
	logic [SW-1:0] den_q;
	logic          neg_q, busy_q;
	logic [6:0]    cnt_q;
	logic [SW:0]   trial;
	logic [SW-1:0] d;
	logic [NW-1:0] mag;

	assign d = (ask < bid) ? SW'(bid - ask) : SW'(ask - bid);
	assign trial = {rem_q[SW-1:0], num_q[NW-1]};
	assign busy = busy_q;
	assign mag = neg_q ? (~quo_q + 1'b1) : quo_q;
	assign result = mag[obtl_pkg::SPREAD_W-1:0];

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 7'(STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 7'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= (NW'(d) * NW'(obtl_pkg::BPS_SCALE)) << obtl_pkg::FRAC_BITS;
			den_q <= SW'(bid) + SW'(ask);
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= ask < bid;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule

FILE: verif/tb_order_book_top_levels.sv
class book_scoreboard;
	bit [obtl_pkg::PRICE_W-1:0] bid_px[$];
	bit [obtl_pkg::QTY_W-1:0] bid_q[$];
	bit [obtl_pkg::PRICE_W-1:0] ask_px[$];
	bit [obtl_pkg::QTY_W-1:0] ask_q[$];
	bit [obtl_pkg::ID_W-1:0] last_id;
	bit inited;
	bit resync;
	bit in_msg;
	bit taken;
	bit [obtl_pkg::CNT_W-1:0] depth_cfg = 6'd5;
	obtl_pkg::out_item_t tob_q[$];
	int errors;

	function bit [obtl_pkg::DEPTH_W-1:0] side_depth(bit [obtl_pkg::QTY_W-1:0] q[$]);
		bit [obtl_pkg::DEPTH_W-1:0] s;
		s = '0;
		for (int i = 0; i < q.size() && i < depth_cfg; i++)
			s += obtl_pkg::DEPTH_W'(q[i]);
		return s;
	endfunction

	function bit [obtl_pkg::SPREAD_W-1:0] spread_of(bit [obtl_pkg::PRICE_W-1:0] b,
		bit [obtl_pkg::PRICE_W-1:0] a);
		bit [63:0] s, d, q, r, m;
		s = 64'(b) + 64'(a);
		if (s == 0)
			return '0;
		d = (a < b) ? 64'(b) - 64'(a) : 64'(a) - 64'(b);
		q = (d * 64'd20000) / s;
		r = (d * 64'd20000) % s;
		m = q;
		for (int k = 0; k < obtl_pkg::FRAC_BITS; k++) begin
			r = r << 1;
			m = m << 1;
			if (r >= s) begin
				r -= s;
				m[0] = 1'b1;
			end
		end
		if (a < b)
			m = 64'd0 - m;
		return m[obtl_pkg::SPREAD_W-1:0];
	endfunction

	function void note_item(obtl_pkg::in_item_t it);
		int pos;
		obtl_pkg::out_item_t o;
		if (!in_msg) begin
			in_msg = 1;
			if (it.opcode == obtl_pkg::OP_UPDATE && inited && it.prev_update_id != last_id) begin
				resync = 1;
				taken = 0;
			end else begin
				taken = 1;
				bid_px.delete(); bid_q.delete(); ask_px.delete(); ask_q.delete();
				last_id = it.end_update_id;
				inited = 1;
				if (it.opcode == obtl_pkg::OP_SNAPSHOT)
					resync = 0;
			end
		end
		if (taken && it.has_level) begin
			if (it.side == obtl_pkg::SIDE_BID && bid_px.size() < obtl_pkg::MAX_LEVELS) begin
				pos = 0;
				while (pos < bid_px.size() && !(bid_px[pos] < it.price)) pos++;
				bid_px.insert(pos, it.price);
				bid_q.insert(pos, it.qty);
			end else if (it.side == obtl_pkg::SIDE_ASK &&
				ask_px.size() < obtl_pkg::MAX_LEVELS) begin
				pos = 0;
				while (pos < ask_px.size() && !(ask_px[pos] > it.price)) pos++;
				ask_px.insert(pos, it.price);
				ask_q.insert(pos, it.qty);
			end
		end
		if (!it.last_of_message)
			return;
		in_msg = 0;
		o = '0;
		o.accepted = taken;
		o.resync_needed = resync;
		o.top_bid = bid_px.size() ? bid_px[0] : '0;
		o.top_ask = ask_px.size() ? ask_px[0] : '0;
		if (bid_px.size() && ask_px.size()) begin
			o.mid_times_two = {1'b0, o.top_bid} + {1'b0, o.top_ask};
			o.spread_bps_q16 = spread_of(o.top_bid, o.top_ask);
		end
		o.bid_depth = side_depth(bid_q);
		o.ask_depth = side_depth(ask_q);
		o.bid_levels = obtl_pkg::CNT_W'(bid_px.size());
		o.ask_levels = obtl_pkg::CNT_W'(ask_px.size());
		tob_q.push_back(o);
		taken = 0;
	endfunction

	task report(string what, logic [63:0] got, logic [63:0] exp);
		$display("mismatch %s: got %0h expected %0h", what, got, exp);
		errors++;
	endtask

	task check_tob(obtl_pkg::out_item_t g);
		obtl_pkg::out_item_t e;
		if (tob_q.size() == 0) begin
			report("unexpected result", 64'd0, 64'd0);
			return;
		end
		e = tob_q.pop_front();
		if (g.accepted !== e.accepted)
			report("accepted", 64'(g.accepted), 64'(e.accepted));
		if (g.resync_needed !== e.resync_needed)
			report("resync_needed", 64'(g.resync_needed), 64'(e.resync_needed));
		if (g.top_bid !== e.top_bid) report("top_bid", 64'(g.top_bid), 64'(e.top_bid));
		if (g.top_ask !== e.top_ask) report("top_ask", 64'(g.top_ask), 64'(e.top_ask));
		if (g.mid_times_two !== e.mid_times_two)
			report("mid_times_two", 64'(g.mid_times_two), 64'(e.mid_times_two));
		if (g.spread_bps_q16 !== e.spread_bps_q16)
			report("spread_bps_q16", 64'(unsigned'(g.spread_bps_q16)),
				64'(unsigned'(e.spread_bps_q16)));
		if (g.bid_depth !== e.bid_depth)
			report("bid_depth", 64'(g.bid_depth), 64'(e.bid_depth));
		if (g.ask_depth !== e.ask_depth)
			report("ask_depth", 64'(g.ask_depth), 64'(e.ask_depth));
		if (g.bid_levels !== e.bid_levels)
			report("bid_levels", 64'(g.bid_levels), 64'(e.bid_levels));
		if (g.ask_levels !== e.ask_levels)
			report("ask_levels", 64'(g.ask_levels), 64'(e.ask_levels));
	endtask
endclass

module tb_order_book_top_levels;
	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	obtl_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 0;
	obtl_pkg::out_item_t out_item;
	logic cfg_we = 0;
	logic [obtl_pkg::CNT_W-1:0] cfg_wdata = '0;

	book_scoreboard sb = new();
	bit calm;
	bit [obtl_pkg::ID_W-1:0] next_id;
	int items_sent;

	order_book_top_levels u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	// check transfers on the output side
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_tob(out_item);

	// receiver with random stall bursts
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 13);
				out_ready <= 0;
				repeat (n) @(negedge clk);
			end
			out_ready <= 1;
		end
	end

	// valid stays high from one item to the next unless an idle burst comes
	task send_item(obtl_pkg::in_item_t it);
		int n;
		if (!calm && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 13);
			in_valid <= 0;
			repeat (n) @(negedge clk);
		end
		in_item <= it;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_item(it);
		items_sent++;
		@(negedge clk);
	endtask

	task drain();
		in_valid <= 0;
		while (sb.tob_q.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task write_depth(logic [obtl_pkg::CNT_W-1:0] v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		sb.depth_cfg = v;
	endtask

	function logic [obtl_pkg::PRICE_W-1:0] rand_wide();
		case ($urandom_range(0, 3))
			0: return obtl_pkg::PRICE_W'({$urandom, $urandom});
			1: return {obtl_pkg::PRICE_W{1'b1}} - obtl_pkg::PRICE_W'($urandom_range(0, 3));
			default: return obtl_pkg::PRICE_W'(1000 + $urandom_range(0, 40));
		endcase
	endfunction

	// one message; kind 0 good snapshot, 1 good update, 2 gapped update
	task send_message(int kind, int nlev);
		obtl_pkg::in_item_t it;
		for (int i = 0; i <= nlev; i++) begin
			it.opcode = (kind == 0) ? obtl_pkg::OP_SNAPSHOT : obtl_pkg::OP_UPDATE;
			it.side = 1'($urandom);
			it.has_level = (i < nlev) ? 1'b1 : 1'($urandom_range(0, 1));
			it.price = rand_wide();
			it.qty = rand_wide();
			it.prev_update_id = (kind == 2) ? {$urandom, $urandom} : sb.last_id;
			it.end_update_id = (i == 0) ? next_id : {$urandom, $urandom};
			it.last_of_message = (i == nlev);
			if (i > 0 && $urandom_range(0, 3) == 0) it.opcode = 1'($urandom);
			send_item(it);
		end
		next_id = {$urandom, $urandom};
	endtask

	initial begin
		#50000000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int k;
		obtl_pkg::in_item_t it;
		next_id = 64'hFFFF_FFFF_FFFF_FFFF;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// update before any snapshot is taken, then snapshot with ties
		send_message(1, 2);
		send_message(0, 0);
		it = '0;
		it.opcode = obtl_pkg::OP_SNAPSHOT;
		it.has_level = 1;
		it.price = '1; it.qty = '1; send_item(it);
		it.qty = obtl_pkg::QTY_W'(7); send_item(it);
		it.side = obtl_pkg::SIDE_ASK; it.price = '0; it.qty = obtl_pkg::QTY_W'(3);
		send_item(it);
		it.price = '1; it.qty = obtl_pkg::QTY_W'(9); it.last_of_message = 1; send_item(it);
		send_message(2, 3);
		send_message(1, 2);
		send_message(0, 3);
		// pause until results drained
		drain();
		write_depth(6'd0);
		send_message(0, 40);
		write_depth(6'd32);
		send_message(0, 70);
		write_depth(6'd63);
		send_message(0, 6);
		while (items_sent < 1900) begin
			if (items_sent > 1600) calm = 1;
			if ($urandom_range(0, 30) == 0)
				write_depth(obtl_pkg::CNT_W'($urandom_range(0, 1) ?
					$urandom_range(0, 33) : $urandom));
			k = $urandom_range(0, 9);
			send_message(k < 3 ? 0 : (k < 8 ? 1 : 2),
				$urandom_range(0, 15) == 0 ? $urandom_range(30, 40) : $urandom_range(0, 8));
		end
		drain();
		if (sb.errors == 0 && sb.tob_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

FILE: order_book_top_levels.f
hw/rtl/obtl_pkg.sv
hw/rtl/obtl_cell.sv
hw/rtl/obtl_side.sv
hw/rtl/obtl_spread.sv
hw/rtl/order_book_top_levels.sv
verif/tb_order_book_top_levels.sv
